// ===== hw/rtl/ddodo_pkg.sv =====
//------------------------------------------------------------------------------
// ddodo_pkg: shared types and constants for the odometry update block
// Fixed-point constants, register indexes, CORDIC arctangent table and
// the state type of the update sequencer.
//------------------------------------------------------------------------------
package ddodo_pkg;

	localparam int CordicSteps = 16;
	localparam int AtanLen     = 30;
	localparam int StepW       = 5;

	localparam logic signed [31:0] PiQ28     = 32'sd843314857;
	localparam logic signed [31:0] TwoPiQ28  = 32'sd1686629713;
	localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
	localparam logic signed [33:0] GainQ30   = 34'sd652032874;

	localparam logic [1:0] REG_DIST  = 2'd0;
	localparam logic [1:0] REG_ANGLE = 2'd1;
	localparam logic [1:0] REG_IPER  = 2'd2;

	// multiply sequence selector
	typedef enum logic [2:0] {
		MUL_HEAD, MUL_DIST, MUL_DX, MUL_DY, MUL_LIN, MUL_ANG
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_REDUCE, ST_CORDIC, ST_DONE
	} state_t;

	function automatic logic signed [31:0] atan_q28(input logic [StepW-1:0] i);
		logic signed [31:0] r;
		begin
			case (i)
				5'd0: r = 32'sd210828714;
				5'd1: r = 32'sd124459457;
				5'd2: r = 32'sd65760959;
				5'd3: r = 32'sd33381290;
				5'd4: r = 32'sd16755422;
				5'd5: r = 32'sd8385879;
				5'd6: r = 32'sd4193963;
				5'd7: r = 32'sd2097109;
				5'd8: r = 32'sd1048571;
				5'd9: r = 32'sd524287;
				default: r = (i >= 5'd29) ? 32'sd0 : (32'sd1 <<< (5'd28 - i));
			endcase
			return r;
		end
	endfunction

endpackage

// ===== hw/rtl/diff_drive_odometry_update.sv =====
//------------------------------------------------------------------------------
// diff_drive_odometry_update: differential-drive odometry integrator
// Heading, position and velocity update from wheel encoder counts.
//------------------------------------------------------------------------------
// One item per transfer, one result per item. Each product runs through a
// shift-and-add multiplier that takes one 2-bit multiplier digit per cycle and
// stops once the remaining digits are zero. A product is loaded, stepped
// through its multiplier digits and finished; the heading and distance
// products have a 32-bit scale, x and y a 22-bit sine/cosine and the
// velocities a 16-bit rate. The angle reduction adds or subtracts 2*pi from
// the mid-interval heading, one step per cycle, until it lies within +-pi,
// then sets up the CORDIC. The CORDIC runs CordicSteps rotations, one per
// cycle; the x, y and velocity products follow, and the last state, ST_DONE,
// writes the output register. The result waits in an output register; a new
// item is taken once the previous update has been written to it, even while
// that result is still waiting. The last cycle of an update holds until the
// output register is free.
//------------------------------------------------------------------------------
module diff_drive_odometry_update
	import ddodo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [14:0] right_count, [29:15] left_count, [31:30] right_dir, [33:32] left_dir
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [47:0] pos_x, [95:48] pos_y, [127:96] heading,
	// [159:128] linear_velocity, [191:160] angular_velocity
	output logic [191:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration
	logic [31:0] dist_q, angle_q;
	logic [15:0] iper_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= 32'd322960;
			angle_q <= 32'd413391;
			iper_q  <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIST:  dist_q  <= cfg_data;
				REG_ANGLE: angle_q <= cfg_data;
				REG_IPER:  iper_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	mul_sel_t sel_q;
	logic out_valid_q;
	logic [191:0] out_data_q;
	logic out_load;

	// item registers
	logic signed [17:0] dd2_q, dth_q;
	logic signed [63:0] x_acc_q, y_acc_q; // low 48 bits kept
	logic signed [31:0] head_q;
	logic signed [63:0] oi_q, dist18_q, mid_q;
	logic signed [63:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic [StepW-1:0]   it_q;
	logic signed [31:0] lin_q, ang_q;

	// serial multiplier: acc += a * digit, a shifted left two bits each cycle
	logic signed [63:0] ma_q;      // multiplicand, shifting
	logic [63:0]        mb_q;      // multiplier magnitude bits, shifting
	logic               mneg_q;    // negate result at end
	logic signed [63:0] macc_q;
	logic [5:0]         mcnt_q;

	// decode of input
	logic [14:0] rc, lc;
	logic [1:0] rd, ld;
	logic signed [17:0] sum, dif, dd2_n, dth_n;
	assign rc = s_axis_tdata[14:0];
	assign lc = s_axis_tdata[29:15];
	assign rd = s_axis_tdata[31:30];
	assign ld = s_axis_tdata[33:32];
	assign sum = 18'(rc) + 18'(lc);
	assign dif = 18'(rc) - 18'(lc);

	always_comb begin
		dd2_n = '0;
		dth_n = '0;
		if (rd == 2'd1 && ld == 2'd1) begin
			dd2_n = sum; dth_n = dif;
		end else if (rd[1] && ld[1]) begin
			dd2_n = -sum; dth_n = -dif;
		end else if (rd[1] && ld == 2'd1) begin
			dd2_n = -dif; dth_n = -sum;
		end else if (rd == 2'd1 && ld[1]) begin
			dd2_n = dif; dth_n = sum;
		end
	end

	logic s_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// last cycle writes the output register once it is free
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
			input logic [4:0] s);
		logic signed [63:0] t;
		begin
			t = v + (64'sd1 <<< (s - 5'd1));
			return t >>> s;
		end
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
			else if (v < -64'sd2147483648) return 32'sh80000000;
			else return v[31:0];
		end
	endfunction

	// operand set-up for each product (signed a, signed b)
	logic signed [63:0] op_a, op_b;
	logic signed [63:0] c21, s21;
	assign c21 = rnd(flip_q ? -cx_q : cx_q, 5'd9);
	assign s21 = rnd(flip_q ? -cy_q : cy_q, 5'd9);

	always_comb begin
		unique case (sel_q)
			MUL_HEAD: begin op_a = 64'(dth_q); op_b = $signed({32'd0, angle_q}); end
			MUL_DIST: begin op_a = 64'(dd2_q); op_b = $signed({32'd0, dist_q}); end
			MUL_DX:   begin op_a = dist18_q;   op_b = c21; end
			MUL_DY:   begin op_a = dist18_q;   op_b = s21; end
			MUL_LIN:  begin op_a = dist18_q;   op_b = $signed({48'd0, iper_q}); end
			MUL_ANG:  begin op_a = oi_q;       op_b = $signed({48'd0, iper_q}); end
			default:  begin op_a = '0;         op_b = '0; end
		endcase
	end

	logic mul_start, mul_done;
	logic signed [63:0] mprod;
	assign mul_done = (state_q == ST_MUL) && (mcnt_q == 6'd0) && !mul_start;
	assign mprod = mneg_q ? -macc_q : macc_q;

	logic signed [63:0] h_sum;
	assign h_sum = 64'(head_q) + oi_q;

	// CORDIC step
	logic signed [63:0] xs, ys;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	logic mul_go_q;
	assign mul_start = mul_go_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_acc) state_d = ST_MUL;
			ST_MUL:    if (mul_done && sel_q == MUL_DIST) state_d = ST_REDUCE;
			           else if (mul_done && sel_q == MUL_ANG) state_d = ST_DONE;
			ST_REDUCE: if (mid_q <= 64'(PiQ28) && mid_q >= -64'(PiQ28)) state_d = ST_CORDIC;
			ST_CORDIC: if (it_q == StepW'(CordicSteps - 1)) state_d = ST_MUL;
			ST_DONE:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			head_q      <= '0;
			sel_q       <= MUL_HEAD;
			mcnt_q      <= '0;
			mul_go_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			mul_go_q <= 1'b0;
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			if (s_acc) begin
				dd2_q    <= dd2_n;
				dth_q    <= dth_n;
				sel_q    <= MUL_HEAD;
				mul_go_q <= 1'b1;
			end
			if (mul_go_q) begin
				// load multiplier with magnitudes
				ma_q   <= op_a[63] ? -op_a : op_a;
				mb_q   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
				mneg_q <= op_a[63] ^ op_b[63];
				macc_q <= '0;
				mcnt_q <= 6'd32;
			end else if (mcnt_q != 6'd0) begin
				macc_q <= macc_q + (mb_q[0] ? ma_q : 64'sd0) + (mb_q[1] ? (ma_q <<< 1) : 64'sd0);
				ma_q   <= ma_q <<< 2;
				mb_q   <= mb_q >> 2;
				mcnt_q <= (mb_q[63:2] == '0) ? 6'd0 : mcnt_q - 6'd1;
			end
			if (mul_done) begin
				unique case (sel_q)
					MUL_HEAD: begin
						oi_q  <= rnd(mprod, 5'd4);
						sel_q <= MUL_DIST;
						mul_go_q <= 1'b1;
					end
					MUL_DIST: begin
						dist18_q <= rnd(mprod, 5'd7);
						mid_q    <= 64'(head_q) + rnd(oi_q, 5'd1);
						if (h_sum > 64'(PiQ28)) head_q <= 32'(h_sum - 64'(TwoPiQ28));
						else if (h_sum < -64'(PiQ28)) head_q <= 32'(h_sum + 64'(TwoPiQ28));
						else head_q <= h_sum[31:0];
					end
					MUL_DX: begin
						x_acc_q <= 64'(48'(x_acc_q + rnd(mprod, 5'd23)));
						sel_q <= MUL_DY; mul_go_q <= 1'b1;
					end
					MUL_DY: begin
						y_acc_q <= 64'(48'(y_acc_q + rnd(mprod, 5'd23)));
						sel_q <= MUL_LIN; mul_go_q <= 1'b1;
					end
					MUL_LIN: begin
						lin_q <= sat(rnd(mprod, 5'd2));
						sel_q <= MUL_ANG; mul_go_q <= 1'b1;
					end
					MUL_ANG: begin
						ang_q <= sat(rnd(mprod, 5'd4));
					end
					default: ;
				endcase
			end
			if (state_q == ST_REDUCE) begin
				// remainder by repeated subtraction toward zero, then fold
				if (mid_q > 64'(TwoPiQ28) - 64'sd1) mid_q <= mid_q - 64'(TwoPiQ28);
				else if (mid_q < -64'(TwoPiQ28) + 64'sd1) mid_q <= mid_q + 64'(TwoPiQ28);
				else if (mid_q > 64'(PiQ28)) mid_q <= mid_q - 64'(TwoPiQ28);
				else if (mid_q < -64'(PiQ28)) mid_q <= mid_q + 64'(TwoPiQ28);
				else begin
					cx_q <= 64'(GainQ30);
					cy_q <= '0;
					it_q <= '0;
					if (mid_q > 64'(HalfPiQ28)) begin
						cz_q <= mid_q - 64'(PiQ28); flip_q <= 1'b1;
					end else if (mid_q < -64'(HalfPiQ28)) begin
						cz_q <= mid_q + 64'(PiQ28); flip_q <= 1'b1;
					end else begin
						cz_q <= mid_q; flip_q <= 1'b0;
					end
				end
			end
			if (state_q == ST_CORDIC) begin
				if (!cz_q[63]) begin
					cx_q <= cx_q - ys; cy_q <= cy_q + xs;
					cz_q <= cz_q - 64'(atan_q28(it_q));
				end else begin
					cx_q <= cx_q + ys; cy_q <= cy_q - xs;
					cz_q <= cz_q + 64'(atan_q28(it_q));
				end
				it_q <= it_q + 1'b1;
				if (it_q == StepW'(CordicSteps - 1)) begin
					sel_q <= MUL_DX; mul_go_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {ang_q, lin_q, head_q, y_acc_q[47:0], x_acc_q[47:0]};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> m_axis_tvalid) else $error("result lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
`endif

endmodule
